FILE: hdl/indexed_list_store_assert.svh
// Assertion macros for the indexed list store checker.
// No dependencies; included by files that assert.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// Property checked out of reset.
`define ILS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("indexed_list_store check failed");

// Property checked also during reset.
`define ILS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("indexed_list_store reset check failed");

`endif

FILE: hdl/ils_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the indexed list store.
// No dependencies.
package ils_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int REQ_W = 2;
  localparam int POS_W = 9;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 9;

  localparam logic [REQ_W-1:0] REQ_READ   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INS,
    CMD_DEL,
    CMD_RDLOAD,
    CMD_RDSHIFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: hdl/ils_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain: a value slot and a read shift stage.
// Depends on ils_pkg.
module ils_cell (
  input  logic                     clk,
  input  ils_pkg::cell_ctrl_t      ctrl,
  input  logic [ils_pkg::IDX_W-1:0] cell_idx,
  input  logic [ils_pkg::VAL_W-1:0] left_val,
  input  logic [ils_pkg::VAL_W-1:0] right_val,
  input  logic [ils_pkg::VAL_W-1:0] right_rd,
  output logic [ils_pkg::VAL_W-1:0] val,
  output logic [ils_pkg::VAL_W-1:0] rd
);
  import ils_pkg::*;

  logic [VAL_W-1:0] val_r, val_nxt;
  logic [VAL_W-1:0] rd_r, rd_nxt;

  always_comb begin
    val_nxt = val_r;
    rd_nxt  = rd_r;
    case (ctrl.cmd)
      CMD_INS: begin
        // open a gap at pos: cells past it take their left neighbor
        if (cell_idx == ctrl.pos) begin
          val_nxt = ctrl.value;
        end else if (cell_idx > ctrl.pos) begin
          val_nxt = left_val;
        end
      end
      CMD_DEL: begin
        if (cell_idx >= ctrl.pos) begin
          val_nxt = right_val;
        end
      end
      CMD_RDLOAD:  rd_nxt = val_r;
      CMD_RDSHIFT: rd_nxt = right_rd;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    rd_r  <= rd_nxt;
  end

  assign val = val_r;
  assign rd  = rd_r;

endmodule

FILE: hdl/indexed_list_store.sv
`timescale 1ns / 1ps
// Top level of the indexed list store: request control and the cell chain.
// Depends on ils_pkg and ils_cell.
//
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+-------------------------
//  request | in_req_type, in_position, in_value         | start high, busy low
//  result  | out_status, out_read_value, out_length     | out_valid, one cycle
//
// For insert, append, delete and any out-of-range or full request, the result
// strobes in the next cycle and a new item is taken then.
// A read in range loads the whole read chain in parallel and shifts it toward
// the head position times, and busy stays high until the result strobes.
// Reset empties the list; slot contents stay unknown until written.
// Results cannot be stalled by the receiver.
module indexed_list_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [ils_pkg::REQ_W-1:0] in_req_type,
  input  logic [ils_pkg::POS_W-1:0] in_position,
  input  logic [ils_pkg::VAL_W-1:0] in_value,
  output logic                      out_valid,
  output logic [ils_pkg::ST_W-1:0]  out_status,
  output logic [ils_pkg::VAL_W-1:0] out_read_value,
  output logic [ils_pkg::LEN_W-1:0] out_length
);
  import ils_pkg::*;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_rd_r, out_rd_nxt;
  logic [LEN_W-1:0] out_length_r, out_length_nxt;

  cell_ctrl_t       ctrl;
  logic             accept;
  logic [CMP_W-1:0] pos_ext, cnt_ext, cap_ext;

  logic [VAL_W-1:0] val_w [CAPACITY];
  logic [VAL_W-1:0] rd_w  [CAPACITY];

  assign accept  = start && (state_r == S_IDLE);
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign cap_ext = CMP_W'(CAPACITY);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_cnt_nxt     = rd_cnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_length_nxt = out_length_r;
    ctrl.cmd       = CMD_NONE;
    ctrl.pos       = in_position[IDX_W-1:0];
    ctrl.value     = in_value;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_rd_nxt     = '0;
          case (in_req_type)
            REQ_READ: begin
              if (pos_ext < cnt_ext) begin
                // result comes out of the read chain later
                out_valid_nxt = 1'b0;
                ctrl.cmd      = CMD_RDLOAD;
                rd_cnt_nxt    = in_position[IDX_W-1:0];
                state_nxt     = S_READ;
              end else begin
                out_status_nxt = ST_RANGE;
                out_rd_nxt     = '1;
              end
            end
            REQ_INSERT: begin
              if (pos_ext > cnt_ext) begin
                out_status_nxt = ST_RANGE;
              end else if (cnt_ext >= cap_ext) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.cmd  = CMD_INS;
                count_nxt = CNT_W'(count_r + 1'b1);
              end
            end
            REQ_APPEND: begin
              if (cnt_ext >= cap_ext) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.cmd  = CMD_INS;
                ctrl.pos  = count_r[IDX_W-1:0];
                count_nxt = CNT_W'(count_r + 1'b1);
              end
            end
            REQ_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = ST_RANGE;
              end else begin
                ctrl.cmd  = CMD_DEL;
                count_nxt = CNT_W'(count_r - 1'b1);
              end
            end
            default: ;
          endcase
          out_length_nxt = LEN_W'(count_nxt);
        end
      end
      S_READ: begin
        if (rd_cnt_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_rd_nxt     = rd_w[0];
          out_length_nxt = LEN_W'(count_r);
          state_nxt      = S_IDLE;
        end else begin
          // advance the read chain one cell toward the head
          ctrl.cmd   = CMD_RDSHIFT;
          rd_cnt_nxt = IDX_W'(rd_cnt_r - 1'b1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_length_r <= out_length_nxt;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_v, right_v, right_r;
    if (i == 0) begin : g_head
      assign left_v = in_value;
    end else begin : g_mid
      assign left_v = val_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = '0;
      assign right_r = '0;
    end else begin : g_body
      assign right_v = val_w[i+1];
      assign right_r = rd_w[i+1];
    end
    ils_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (IDX_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .right_rd  (right_r),
      .val       (val_w[i]),
      .rd        (rd_w[i])
    );
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_rd_r;
  assign out_length     = out_length_r;

endmodule

FILE: hdl/ils_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the indexed list store, bound to the top level.
// Depends on ils_pkg and indexed_list_store_assert.svh.
`include "indexed_list_store_assert.svh"

module ils_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [ils_pkg::ST_W-1:0]  out_status,
  input logic [ils_pkg::VAL_W-1:0] out_read_value,
  input logic [ils_pkg::LEN_W-1:0] out_length
);
  import ils_pkg::*;

  `ILS_ASSERT_RST(a_no_strobe_after_reset, clk, !rst_n |=> !out_valid)
  `ILS_ASSERT(a_item_progresses, clk, rst_n, (start && !busy) |=> (out_valid || busy))
  `ILS_ASSERT(a_idle_on_result, clk, rst_n, out_valid |-> !busy)
  `ILS_ASSERT(a_length_bound, clk, rst_n,
              out_valid |-> (out_length <= LEN_W'(CAPACITY) && out_status != 2'd3))
  `ILS_ASSERT(a_full_only_at_cap, clk, rst_n,
              (out_valid && out_status == ST_FULL) |-> (out_length == LEN_W'(CAPACITY)
               && out_read_value == '0))

endmodule

bind indexed_list_store ils_checker u_ils_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_read_value (out_read_value),
  .out_length     (out_length)
);
